@@ design/evad_pkg.sv @@
// Shared constants, types and the square-root table for the energy-based
// voice activity detector. No dependencies; every other design file uses it.

package evad_pkg;

   // Block configuration
   localparam int VOTE_WINDOW       = 5;
   localparam int MAX_FRAME_SAMPLES = 4096;

   // Field and port widths
   localparam int SAMPLE_W    = 16;
   localparam int FTIME_W     = 32;
   localparam int REQ_DATA_W  = 48;
   localparam int RMS_W       = 16;
   localparam int VOTES_W     = 6;
   localparam int RSP_DATA_W  = 32;
   localparam int THR_W       = 17;
   localparam int HOLD_W      = 40;
   localparam int CSR_DATA_W  = 40;
   localparam int CSR_ADDR_W  = 1;

   // Datapath widths
   localparam int COUNT_W     = $clog2(MAX_FRAME_SAMPLES + 1);
   localparam int SQ_W        = 31;
   localparam int SUM_W       = 31;
   localparam int SUM_KEEP_W  = 17;
   localparam int SHIFT_W     = 6;
   localparam int QUIET_W     = 41;
   localparam int POWER_W     = 32;
   localparam int DIVIDEND_W  = 49;
   localparam int DIVISOR_W   = COUNT_W;
   localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);
   localparam int LG_W        = 5;
   localparam int IDX_W       = 7;
   localparam int ROOT_TAB_LEN = 96;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_THRESHOLD = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_HOLD      = 1'd1;

   // Reset values and arithmetic constants
   localparam logic signed [THR_W-1:0] THR_RESET  = 17'sd256;
   localparam logic [HOLD_W-1:0]       HOLD_RESET = 40'd500000000;
   localparam logic [SUM_W-1:0]        SUM_LIMIT  = 31'h10000;
   localparam logic [SHIFT_W-1:0]      SHIFT_MAX  = 6'd63;
   localparam logic [SHIFT_W-1:0]      SHIFT_ZERO_ADD = 6'd31;
   localparam logic [SHIFT_W-1:0]      Q15_SHIFT  = 6'd15;
   localparam logic [SHIFT_W-1:0]      MAX_LEFT   = 6'd32;
   localparam logic [RMS_W-1:0]        RMS_OF_ONE = 16'd181;
   localparam logic [IDX_W-1:0]        IDX_LAST   = 7'd95;

   // Status of the divider
   typedef struct packed {
      logic busy;
      logic done;
   } evad_div_status_type;

   // Fractional part of sqrt on one octave pair, Q15
   localparam logic [15:0] ROOT_TAB [0:ROOT_TAB_LEN-1] = '{
      16'd0,     16'd508,   16'd1008,  16'd1501,  16'd1987,  16'd2467,  16'd2940,
      16'd3406,  16'd3867,  16'd4322,  16'd4772,  16'd5216,  16'd5655,  16'd6090,
      16'd6519,  16'd6944,  16'd7364,  16'd7780,  16'd8191,  16'd8599,  16'd9003,
      16'd9402,  16'd9798,  16'd10191, 16'd10579, 16'd10965, 16'd11347, 16'd11725,
      16'd12101, 16'd12473, 16'd12843, 16'd13209, 16'd13572, 16'd13933, 16'd14291,
      16'd14646, 16'd14999, 16'd15349, 16'd15696, 16'd16041, 16'd16384, 16'd16724,
      16'd17061, 16'd17397, 16'd17730, 16'd18062, 16'd18391, 16'd18717, 16'd19042,
      16'd19365, 16'd19686, 16'd20005, 16'd20322, 16'd20637, 16'd20950, 16'd21261,
      16'd21571, 16'd21879, 16'd22185, 16'd22490, 16'd22792, 16'd23093, 16'd23393,
      16'd23691, 16'd23987, 16'd24282, 16'd24576, 16'd24867, 16'd25158, 16'd25447,
      16'd25734, 16'd26020, 16'd26305, 16'd26588, 16'd26870, 16'd27151, 16'd27430,
      16'd27708, 16'd27985, 16'd28261, 16'd28535, 16'd28808, 16'd29080, 16'd29350,
      16'd29620, 16'd29888, 16'd30155, 16'd30422, 16'd30686, 16'd30950, 16'd31213,
      16'd31475, 16'd31735, 16'd31995, 16'd32253, 16'd32511
   };

endpackage

@@ design/evad_div.sv @@
// Restoring divider, one quotient bit per cycle, used for the frame power.
// Depends on evad_pkg for widths and the status struct.

module evad_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [evad_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [evad_pkg::DIVISOR_W-1:0]    divisor,
   output evad_pkg::evad_div_status_type     status,
   output logic [evad_pkg::DIVIDEND_W-1:0]   quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [evad_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [evad_pkg::DIVIDEND_W-1:0]   quo_ff, quo_in;
   logic [evad_pkg::DIVISOR_W-1:0]    rem_ff, rem_in;
   logic [evad_pkg::DIVISOR_W-1:0]    dsr_ff, dsr_in;
   logic [evad_pkg::DIVISOR_W:0]      trial;
   logic                              fits;

   // Bring down the next dividend bit and try a subtract.
   assign trial = {rem_ff, quo_ff[evad_pkg::DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[evad_pkg::DIVIDEND_W-2:0], fits};
         rem_in = fits ? evad_pkg::DIVISOR_W'(trial - {1'b0, dsr_ff})
                       : evad_pkg::DIVISOR_W'(trial);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == evad_pkg::DIV_CNT_W'(evad_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

@@ design/energy_voice_activity_detector_top.sv @@
// Top level of the energy-based voice activity detector: sequencer, datapath
// and output register. Depends on evad_pkg and instantiates evad_div.
//
// Channel   Ports                      Contents (low bit first)
// request   req_tvalid/tready/tdata    tdata: sample[15:0], frame_time[47:16]
//           req_tlast                  frame_end
// response  rsp_tvalid/tready/tdata    tdata: rms_level[15:0], loud_votes[21:16],
//                                      speech_active[22], speech_start[23],
//                                      speech_stop[24], zero[31:25]
// config    csr_wen/csr_addr/csr_wdata index 0 speech_threshold, 1 silence_hold_time
//
// A sample passes through the square, add and normalise states, with one normalise
// step per halving of the running sum; requests are taken only in the idle state.
// A frame-end sample that divides goes through divider setup, the bit-serial divider,
// the leading-one search, index and root (for a power above one), vote, quiet, decision
// and emit states. An empty sum or an oversized left shift skips the divider.
// Reset is synchronous and takes effect at once; there is no clearing pass.
// A stalled response holds only a finished frame result; samples are still taken
// while the previous result waits in the output register.

module energy_voice_activity_detector_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [evad_pkg::REQ_DATA_W-1:0]    req_tdata,   // sample, frame_time
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [evad_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // rms_level, loud_votes,
                                                           // speech_active, speech_start,
                                                           // speech_stop
   input  logic                               csr_wen,
   input  logic [evad_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [evad_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SQUARE = 4'd1;
   localparam logic [3:0] ST_ADD    = 4'd2;
   localparam logic [3:0] ST_NORM   = 4'd3;
   localparam logic [3:0] ST_PREP   = 4'd4;
   localparam logic [3:0] ST_DIV    = 4'd5;
   localparam logic [3:0] ST_LGINIT = 4'd6;
   localparam logic [3:0] ST_LG     = 4'd7;
   localparam logic [3:0] ST_INDEX  = 4'd8;
   localparam logic [3:0] ST_ROOT   = 4'd9;
   localparam logic [3:0] ST_VOTE   = 4'd10;
   localparam logic [3:0] ST_QUIET  = 4'd11;
   localparam logic [3:0] ST_DECIDE = 4'd12;
   localparam logic [3:0] ST_EMIT   = 4'd13;

   localparam int W = evad_pkg::VOTE_WINDOW;

   // Control and architectural state
   logic [3:0]                            state_ff, state_in;
   logic [evad_pkg::COUNT_W-1:0]          count_ff, count_in;
   logic [evad_pkg::SUM_W-1:0]            sum_ff, sum_in;
   logic [evad_pkg::SHIFT_W-1:0]          shift_ff, shift_in;
   logic [W-1:0]                          hist_ff, hist_in;
   logic                                  silent_ff, silent_in;
   logic [evad_pkg::QUIET_W-1:0]          quiet_ff, quiet_in;
   logic signed [evad_pkg::THR_W-1:0]     thr_ff;
   logic [evad_pkg::HOLD_W-1:0]           hold_ff;
   logic                                  rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic signed [evad_pkg::SAMPLE_W-1:0]  sample_ff, sample_in;
   logic                                  last_ff, last_in;
   logic [evad_pkg::FTIME_W-1:0]          ftime_ff, ftime_in;
   logic [evad_pkg::SQ_W-1:0]             sq_ff, sq_in;
   logic [evad_pkg::POWER_W-1:0]          power_ff, power_in;
   logic [evad_pkg::LG_W-1:0]             lg_ff, lg_in;
   logic [evad_pkg::IDX_W-1:0]            idx_ff, idx_in;
   logic [evad_pkg::RMS_W-1:0]            rms_ff, rms_in;
   logic                                  prev_ff, prev_in;
   logic [evad_pkg::VOTES_W-1:0]          votes_ff, votes_in;
   logic [evad_pkg::RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;

   // Datapath signals
   logic signed [2*evad_pkg::SAMPLE_W-1:0] product;
   logic [evad_pkg::SHIFT_W-1:0]          left_amt;
   logic [3:0]                            right_amt;
   logic [evad_pkg::DIVISOR_W-1:0]        divisor;
   logic [evad_pkg::DIVIDEND_W-1:0]       dividend;
   logic                                  div_start;
   evad_pkg::evad_div_status_type         div_status;
   logic [evad_pkg::DIVIDEND_W-1:0]       quotient;
   logic [evad_pkg::DIVIDEND_W-1:0]       quo_shr;
   logic [36:0]                           mant;
   logic [36:0]                           scaled;
   logic [4:0]                            root_exp;
   logic [23:0]                           root_base;
   logic [38:0]                           root_frac;
   logic [24:0]                           root_sum;
   logic                                  loud;
   logic [evad_pkg::VOTES_W-1:0]          votes_now;
   logic [evad_pkg::QUIET_W:0]            quiet_sum;

   // Request handshake
   assign req_tready = (state_ff == ST_IDLE);

   // Square of the sample
   assign product = sample_ff * sample_ff;

   // Power scaling amounts and the divider operands
   assign left_amt  = shift_ff - evad_pkg::Q15_SHIFT;
   assign right_amt = 4'(evad_pkg::Q15_SHIFT - shift_ff);
   assign divisor   = (count_ff == '0) ? evad_pkg::DIVISOR_W'(1) : count_ff;
   assign dividend  = (shift_ff > evad_pkg::Q15_SHIFT)
                      ? (evad_pkg::DIVIDEND_W'(sum_ff[evad_pkg::SUM_KEEP_W-1:0]) << left_amt)
                      : evad_pkg::DIVIDEND_W'(sum_ff[evad_pkg::SUM_KEEP_W-1:0]);
   assign quo_shr   = quotient >> right_amt;

   evad_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .status   (div_status),
      .quotient (quotient)
   );

   // Table index: offset above the octave base, scaled to 32 steps per octave
   assign mant   = 37'(power_ff) - (37'(1) << lg_ff);
   assign scaled = (mant << 5) >> lg_ff;

   // Root: 2^(8+lg/2) * (1 + table/2^15)
   assign root_exp  = 5'd8 + 5'(lg_ff[evad_pkg::LG_W-1:1]);
   assign root_base = 24'(1) << root_exp;
   assign root_frac = (39'(evad_pkg::ROOT_TAB[idx_ff]) << root_exp) >> 15;
   assign root_sum  = 25'(root_base) + 25'(root_frac[23:0]);

   // Loudness compare is signed against the threshold
   assign loud = $signed({1'b0, rms_ff}) > thr_ff;

   // Loud frames in the vote window
   always_comb begin
      votes_now = '0;
      for (int i = 0; i < W; i++) begin
         votes_now = votes_now + evad_pkg::VOTES_W'(hist_ff[i]);
      end
   end

   assign quiet_sum = {1'b0, quiet_ff} + (evad_pkg::QUIET_W + 1)'(ftime_ff);

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      shift_in     = shift_ff;
      hist_in      = hist_ff;
      silent_in    = silent_ff;
      quiet_in     = quiet_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      ftime_in     = ftime_ff;
      sq_in        = sq_ff;
      power_in     = power_ff;
      lg_in        = lg_ff;
      idx_in       = idx_ff;
      rms_in       = rms_ff;
      prev_in      = prev_ff;
      votes_in     = votes_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata[evad_pkg::SAMPLE_W-1:0];
               ftime_in  = req_tdata[evad_pkg::REQ_DATA_W-1:evad_pkg::SAMPLE_W];
               last_in   = req_tlast;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sq_in    = product[evad_pkg::SQ_W-1:0];
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (shift_ff < evad_pkg::SHIFT_ZERO_ADD) begin
               sum_in = sum_ff + (sq_ff >> shift_ff);
            end
            if (count_ff < evad_pkg::COUNT_W'(evad_pkg::MAX_FRAME_SAMPLES)) begin
               count_in = count_ff + 1'b1;
            end
            state_in = ST_NORM;
         end
         // Halve the sum one step per cycle while above the limit; clamp at SHIFT_MAX.
         ST_NORM: begin
            if (sum_ff > evad_pkg::SUM_LIMIT) begin
               if (shift_ff == evad_pkg::SHIFT_MAX) begin
                  sum_in = evad_pkg::SUM_LIMIT;
               end else begin
                  sum_in   = sum_ff >> 1;
                  shift_in = shift_ff + 1'b1;
               end
            end else begin
               state_in = last_ff ? ST_PREP : ST_IDLE;
            end
         end
         // Empty sum or an oversized left shift bypass the divider.
         ST_PREP: begin
            if (shift_ff > evad_pkg::Q15_SHIFT && sum_ff == '0) begin
               power_in = '0;
               state_in = ST_LGINIT;
            end else if (shift_ff > evad_pkg::Q15_SHIFT && left_amt > evad_pkg::MAX_LEFT) begin
               power_in = '1;
               state_in = ST_LGINIT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (shift_ff > evad_pkg::Q15_SHIFT) begin
                  power_in = (quotient[evad_pkg::DIVIDEND_W-1:evad_pkg::POWER_W] != '0)
                             ? '1 : quotient[evad_pkg::POWER_W-1:0];
               end else begin
                  power_in = quo_shr[evad_pkg::POWER_W-1:0];
               end
               state_in = ST_LGINIT;
            end
         end
         ST_LGINIT: begin
            if (power_ff == '0) begin
               rms_in   = '0;
               state_in = ST_VOTE;
            end else if (power_ff == evad_pkg::POWER_W'(1)) begin
               rms_in   = evad_pkg::RMS_OF_ONE;
               state_in = ST_VOTE;
            end else begin
               lg_in    = '1;
               state_in = ST_LG;
            end
         end
         // Leading-one search, one bit per cycle; the exponent is made odd.
         ST_LG: begin
            if (power_ff[lg_ff]) begin
               lg_in    = lg_ff[0] ? lg_ff : lg_ff - 1'b1;
               state_in = ST_INDEX;
            end else begin
               lg_in = lg_ff - 1'b1;
            end
         end
         ST_INDEX: begin
            idx_in   = (scaled > 37'(evad_pkg::IDX_LAST)) ? evad_pkg::IDX_LAST
                                                         : scaled[evad_pkg::IDX_W-1:0];
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rms_in   = (root_sum > 25'(16'hFFFF)) ? 16'hFFFF : root_sum[evad_pkg::RMS_W-1:0];
            state_in = ST_VOTE;
         end
         ST_VOTE: begin
            hist_in  = (hist_ff >> 1) | (W'(loud) << (W - 1));
            prev_in  = silent_ff;
            state_in = ST_QUIET;
         end
         // Majority starts speech; otherwise quiet time builds up and saturates.
         ST_QUIET: begin
            votes_in = votes_now;
            if (votes_now > evad_pkg::VOTES_W'(W / 2)) begin
               quiet_in  = '0;
               silent_in = 1'b0;
            end else begin
               quiet_in = quiet_sum[evad_pkg::QUIET_W] ? '1 : quiet_sum[evad_pkg::QUIET_W-1:0];
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (quiet_ff > {1'b0, hold_ff}) begin
               silent_in = 1'b1;
            end
            state_in = ST_EMIT;
         end
         // Hand the frame result to the output register once it is free.
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {7'd0, !prev_ff && silent_ff, prev_ff && !silent_ff,
                               !silent_ff, votes_ff, rms_ff};
               rsp_valid_in = 1'b1;
               count_in     = '0;
               sum_in       = '0;
               shift_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, architectural state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         shift_ff     <= '0;
         hist_ff      <= '0;
         silent_ff    <= 1'b1;
         quiet_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= evad_pkg::THR_RESET;
         hold_ff      <= evad_pkg::HOLD_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         shift_ff     <= shift_in;
         hist_ff      <= hist_in;
         silent_ff    <= silent_in;
         quiet_ff     <= quiet_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_addr)
               evad_pkg::REG_THRESHOLD: begin
                  thr_ff <= csr_wdata[evad_pkg::THR_W-1:0];
               end
               evad_pkg::REG_HOLD: begin
                  hold_ff <= csr_wdata[evad_pkg::HOLD_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      ftime_ff    <= ftime_in;
      sq_ff       <= sq_in;
      power_ff    <= power_in;
      lg_ff       <= lg_in;
      idx_ff      <= idx_in;
      rms_ff      <= rms_in;
      prev_ff     <= prev_in;
      votes_ff    <= votes_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ design/evad_checker.sv @@
// Port-level checks for the voice activity detector top level, bound to it.
// Depends on evad_pkg for field positions and the vote window size.

module evad_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [evad_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int ACTIVE_BIT = evad_pkg::RMS_W + evad_pkg::VOTES_W;
   localparam int START_BIT  = ACTIVE_BIT + 1;
   localparam int STOP_BIT   = ACTIVE_BIT + 2;

   // A pending response is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   // A start pulse comes with speech on, a stop pulse with speech off.
   a_pulse_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[START_BIT] || rsp_tdata[ACTIVE_BIT])
                  && (!rsp_tdata[STOP_BIT] || !rsp_tdata[ACTIVE_BIT]))
      else $error("transition pulse disagrees with speech state");

   // The vote count never exceeds the window.
   a_votes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[evad_pkg::RMS_W +: evad_pkg::VOTES_W]
                     <= evad_pkg::VOTES_W'(evad_pkg::VOTE_WINDOW))
      else $error("vote count beyond window");

endmodule

bind energy_voice_activity_detector_top evad_checker u_evad_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
